FILE: rtl/bvwm_pkg.sv
// ----------------------------------------------------------------------------
// Battery voltage window monitor package
// Shared types, codes and constants of the window monitor.
// ----------------------------------------------------------------------------
package bvwm_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int MAX_SAMPLE = 4095;
   localparam int MV_W       = 14;
   localparam int PCT_W      = 7;
   localparam int TIME_W     = 32;
   localparam int LIMIT_W    = 14;
   localparam int GAP_W      = 12;
   localparam int ELAPSE_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int STATUS_W   = 2;
   localparam int SEG_W      = 4;
   localparam int MV_PROD_W  = 17;
   localparam int PCT_DEN_W  = 9;
   localparam int PCT_NUM_W  = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ELAPSE     = 2'd2;

   localparam logic [LIMIT_W-1:0]  LOW_LIMIT_RESET = 14'd7000;
   localparam logic [GAP_W-1:0]    GAP_RESET       = 12'd50;
   localparam logic [ELAPSE_W-1:0] ELAPSE_RESET    = 16'd60;

   localparam logic KIND_SAMPLE   = 1'b0;
   localparam logic KIND_EVALUATE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_EMPTY         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NONE_ACCEPTED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EVALUATED     = 2'd2;

   localparam logic [MV_W:0]    REF_MARGIN_MV = 15'd100;
   localparam logic [MV_W:0]    REF_STEP_MV   = 15'd150;
   localparam logic [1:0]       LOW_RUN_MAX   = 2'd3;
   localparam logic [3:0]       MV_DIVISOR    = 4'd10;
   localparam logic [PCT_W-1:0] PCT_STEP      = 7'd10;
   localparam logic [PCT_W-1:0] PCT_FULL      = 7'd100;
   localparam logic [SEG_W-1:0] PCT_POINTS    = 4'd11;

   typedef enum logic [1:0] {
      WIN_IDLE,
      WIN_MAX,
      WIN_SUM,
      WIN_DONE
   } win_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_AVG,
      ST_MV,
      ST_UPDATE,
      ST_SEG,
      ST_PCT,
      ST_DONE
   } top_state_type;

   typedef struct packed {
      logic push;
      logic start;
   } win_ctrl_type;

   typedef struct packed {
      logic done;
      logic empty;
   } win_stat_type;

   function automatic logic [MV_W-1:0] pct_point(input logic [SEG_W-1:0] idx);
      logic [MV_W-1:0] mv;
      unique case (idx)
         4'd0:    mv = 14'd6500;
         4'd1:    mv = 14'd6840;
         4'd2:    mv = 14'd7020;
         4'd3:    mv = 14'd7160;
         4'd4:    mv = 14'd7240;
         4'd5:    mv = 14'd7300;
         4'd6:    mv = 14'd7360;
         4'd7:    mv = 14'd7460;
         4'd8:    mv = 14'd7580;
         4'd9:    mv = 14'd7740;
         default: mv = 14'd7940;
      endcase
      return mv;
   endfunction

endpackage

FILE: rtl/battery_voltage_window_monitor.sv
// ----------------------------------------------------------------------------
// Battery voltage window monitor
// The req channel carries one beat per item: kind 0 pushes a raw ADC sample
// into the window, kind 1 evaluates the window at time req_time_now. A sample
// beat gives no rsp beat. An evaluate beat gives one rsp beat with the
// filtered voltage, the slow-falling reference, the charge percentage and
// the alarm flags. An evaluation makes two passes of the window past its
// single tap, then three passes of the 17-bit serial divider (as wide as
// the window sum above a depth of 32). One item is worked on at a time;
// req_stall stays high until the result sits in the output register.
// A finished result waits in that register while rsp_stall is high, and the
// next item may be taken meanwhile; a later result waits for it to drain.
// Reset clears the window, the reference, the alarm latch and the counters,
// and loads the register reset values. The csr port writes a register; the
// user must use it only while the block is idle, as the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module battery_voltage_window_monitor
   import bvwm_pkg::*;
#(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic [TIME_W-1:0]     req_time_now,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [MV_W-1:0]       rsp_battery_mv,
   output logic [MV_W-1:0]       rsp_reference_mv,
   output logic [PCT_W-1:0]      rsp_percent,
   output logic                  rsp_store_reference,
   output logic                  rsp_raise_alarm,
   output logic                  rsp_low_latched
);

   localparam int SUM_W  = $clog2(WINDOW_DEPTH * MAX_SAMPLE + 1);
   localparam int ACC_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int DIV_DW = (SUM_W > MV_PROD_W) ? SUM_W : MV_PROD_W;
   localparam int DIV_VW = (ACC_W > PCT_DEN_W) ? ACC_W : PCT_DEN_W;

   top_state_type       state_ff, state_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [GAP_W-1:0]    gap_ff, gap_in;
   logic [ELAPSE_W-1:0] elapse_ff, elapse_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [MV_W-1:0]     ref_ff, ref_in;
   logic [TIME_W-1:0]   ref_time_ff, ref_time_in;
   logic [1:0]          low_cnt_ff, low_cnt_in;
   logic                alarm_ff, alarm_in;
   logic [PCT_W-1:0]    last_pct_ff, last_pct_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [MV_W-1:0]     mv_ff, mv_in;
   logic                store_ff, store_in;
   logic                raise_ff, raise_in;
   logic [SEG_W-1:0]    seg_ff, seg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [MV_W-1:0]     rsp_mv_ff, rsp_mv_in;
   logic [MV_W-1:0]     rsp_ref_ff, rsp_ref_in;
   logic [PCT_W-1:0]    rsp_pct_ff, rsp_pct_in;
   logic                rsp_store_ff, rsp_store_in;
   logic                rsp_raise_ff, rsp_raise_in;
   logic                rsp_latched_ff, rsp_latched_in;

   win_ctrl_type        win_ctrl;
   win_stat_type        win_stat;
   logic [SUM_W-1:0]    win_sum;
   logic [ACC_W-1:0]    win_acc;

   logic                div_start;
   logic [DIV_DW-1:0]   div_dividend;
   logic [DIV_VW-1:0]   div_divisor;
   logic                div_done;
   logic [DIV_DW-1:0]   div_quotient;

   logic                req_accept;
   logic                rsp_free;
   logic [SAMPLE_W-1:0] avg;
   logic [MV_PROD_W-1:0] mv_prod;
   logic [MV_W-1:0]     ref_base;
   logic [TIME_W-1:0]   time_base;
   logic [TIME_W-1:0]   elapsed;
   logic [MV_W:0]       mv_margin;
   logic [MV_W:0]       mv_step;
   logic                capture;
   logic                drop;
   logic [MV_W-1:0]     ref_new;
   logic                low;
   logic [1:0]          cnt_new;
   logic                check;
   logic                raise;
   logic [SEG_W-1:0]    seg;
   logic                in_range;
   logic [SEG_W-1:0]    lo_idx;
   logic [SEG_W-1:0]    hi_idx;
   logic [MV_W-1:0]     lo_mv;
   logic [MV_W-1:0]     span;
   logic [MV_W-1:0]     offset;
   logic [PCT_NUM_W-1:0] offset10;
   logic [SEG_W-1:0]    seg_m1;
   logic [PCT_W-1:0]    pct;

   bvwm_window #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (win_ctrl),
      .sample   (req_sample),
      .gap      (gap_ff),
      .stat     (win_stat),
      .sum      (win_sum),
      .accepted (win_acc)
   );

   bvwm_divider #(
      .DIVIDEND_W(DIV_DW),
      .DIVISOR_W (DIV_VW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign req_stall      = state_ff != ST_IDLE;
   assign req_accept     = req_valid && !req_stall;
   assign rsp_free       = !rsp_valid_ff || !rsp_stall;
   assign win_ctrl.push  = req_accept && (req_kind == KIND_SAMPLE);
   assign win_ctrl.start = req_accept && (req_kind == KIND_EVALUATE);

   always_comb begin
      limit_in  = limit_ff;
      gap_in    = gap_ff;
      elapse_in = elapse_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LOW_LIMIT: limit_in  = csr_write_data[LIMIT_W-1:0];
            CSR_GAP:       gap_in    = csr_write_data[GAP_W-1:0];
            CSR_ELAPSE:    elapse_in = csr_write_data[ELAPSE_W-1:0];
            default:       limit_in  = limit_ff;
         endcase
      end
   end

   always_comb begin
      avg     = div_quotient[SAMPLE_W-1:0];
      mv_prod = {1'b0, avg, 4'b0} + {2'b0, avg, 3'b0} + {4'b0, avg, 1'b0};

      capture   = ref_ff == '0;
      ref_base  = capture ? mv_ff : ref_ff;
      time_base = capture ? now_ff : ref_time_ff;
      elapsed   = now_ff - time_base;
      mv_margin = {1'b0, mv_ff} + REF_MARGIN_MV;
      mv_step   = {1'b0, mv_ff} + REF_STEP_MV;
      drop      = (mv_margin < {1'b0, ref_base}) &&
                  (elapsed > TIME_W'(elapse_ff));
      if (!drop) begin
         ref_new = ref_base;
      end else if (mv_step < {1'b0, ref_base}) begin
         ref_new = ref_base - REF_STEP_MV[MV_W-1:0];
      end else begin
         ref_new = mv_ff;
      end
      low = mv_ff < limit_ff;
      if (!low) begin
         cnt_new = 2'd0;
      end else if (low_cnt_ff == LOW_RUN_MAX) begin
         cnt_new = LOW_RUN_MAX;
      end else begin
         cnt_new = low_cnt_ff + 2'd1;
      end
      check = !low || (cnt_new == LOW_RUN_MAX);
      raise = check && low && (ref_new < limit_ff) && !alarm_ff;

      seg = '0;
      for (int k = 0; k < 11; k++) begin
         if (ref_ff >= pct_point(SEG_W'(k))) begin
            seg = SEG_W'(k + 1);
         end
      end
      in_range = (seg != '0) && (seg != PCT_POINTS);
      lo_idx   = in_range ? seg - SEG_W'(1) : '0;
      hi_idx   = in_range ? seg : SEG_W'(1);
      lo_mv    = pct_point(lo_idx);
      span     = pct_point(hi_idx) - lo_mv;
      offset   = ref_ff - lo_mv;
      offset10 = {offset[PCT_DEN_W-1:0], 3'b0} + {2'b0, offset[PCT_DEN_W-1:0], 1'b0};

      seg_m1 = seg_ff - SEG_W'(1);
      if (seg_ff == '0) begin
         pct = '0;
      end else if (seg_ff == PCT_POINTS) begin
         pct = PCT_FULL;
      end else begin
         pct = div_quotient[PCT_W-1:0] + PCT_W'({3'b0, seg_m1} * PCT_STEP);
      end
   end

   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      ref_in         = ref_ff;
      ref_time_in    = ref_time_ff;
      low_cnt_in     = low_cnt_ff;
      alarm_in       = alarm_ff;
      last_pct_in    = last_pct_ff;
      status_in      = status_ff;
      mv_in          = mv_ff;
      store_in       = store_ff;
      raise_in       = raise_ff;
      seg_in         = seg_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_status_in  = rsp_status_ff;
      rsp_mv_in      = rsp_mv_ff;
      rsp_ref_in     = rsp_ref_ff;
      rsp_pct_in     = rsp_pct_ff;
      rsp_store_in   = rsp_store_ff;
      rsp_raise_in   = rsp_raise_ff;
      rsp_latched_in = rsp_latched_ff;
      div_start      = 1'b0;
      div_dividend   = DIV_DW'(win_sum);
      div_divisor    = DIV_VW'(win_acc);
      unique case (state_ff)
         ST_IDLE: begin
            if (win_ctrl.start) begin
               now_in   = req_time_now;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (win_stat.done) begin
               mv_in    = '0;
               store_in = 1'b0;
               raise_in = 1'b0;
               if (win_stat.empty) begin
                  status_in = STATUS_EMPTY;
                  state_in  = ST_DONE;
               end else if (win_acc == '0) begin
                  status_in = STATUS_NONE_ACCEPTED;
                  state_in  = ST_DONE;
               end else begin
                  status_in = STATUS_EVALUATED;
                  div_start = 1'b1;
                  state_in  = ST_AVG;
               end
            end
         end
         ST_AVG: begin
            div_dividend = DIV_DW'(mv_prod);
            div_divisor  = DIV_VW'(MV_DIVISOR);
            if (div_done) begin
               div_start = 1'b1;
               state_in  = ST_MV;
            end
         end
         ST_MV: begin
            if (div_done) begin
               mv_in    = div_quotient[MV_W-1:0];
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            ref_in      = ref_new;
            ref_time_in = (capture || drop) ? now_ff : ref_time_ff;
            store_in    = capture || drop;
            low_cnt_in  = cnt_new;
            alarm_in    = alarm_ff || raise;
            raise_in    = raise;
            state_in    = ST_SEG;
         end
         ST_SEG: begin
            seg_in       = seg;
            div_start    = 1'b1;
            div_dividend = in_range ? DIV_DW'(offset10) : '0;
            div_divisor  = in_range ? DIV_VW'(span[PCT_DEN_W-1:0]) : DIV_VW'(1);
            state_in     = ST_PCT;
         end
         ST_PCT: begin
            if (div_done) begin
               last_pct_in = pct;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_mv_in      = mv_ff;
               rsp_ref_in     = ref_ff;
               rsp_pct_in     = last_pct_ff;
               rsp_store_in   = store_ff;
               rsp_raise_in   = raise_ff;
               rsp_latched_in = alarm_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LOW_LIMIT_RESET;
         gap_ff       <= GAP_RESET;
         elapse_ff    <= ELAPSE_RESET;
         ref_ff       <= '0;
         ref_time_ff  <= '0;
         low_cnt_ff   <= '0;
         alarm_ff     <= 1'b0;
         last_pct_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         gap_ff       <= gap_in;
         elapse_ff    <= elapse_in;
         ref_ff       <= ref_in;
         ref_time_ff  <= ref_time_in;
         low_cnt_ff   <= low_cnt_in;
         alarm_ff     <= alarm_in;
         last_pct_ff  <= last_pct_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff         <= now_in;
      status_ff      <= status_in;
      mv_ff          <= mv_in;
      store_ff       <= store_in;
      raise_ff       <= raise_in;
      seg_ff         <= seg_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_mv_ff      <= rsp_mv_in;
      rsp_ref_ff     <= rsp_ref_in;
      rsp_pct_ff     <= rsp_pct_in;
      rsp_store_ff   <= rsp_store_in;
      rsp_raise_ff   <= rsp_raise_in;
      rsp_latched_ff <= rsp_latched_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_battery_mv      = rsp_mv_ff;
   assign rsp_reference_mv    = rsp_ref_ff;
   assign rsp_percent         = rsp_pct_ff;
   assign rsp_store_reference = rsp_store_ff;
   assign rsp_raise_alarm     = rsp_raise_ff;
   assign rsp_low_latched     = rsp_latched_ff;

endmodule

FILE: rtl/bvwm_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division that settles one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bvwm_divider #(
   parameter int DIVIDEND_W = 17,
   parameter int DIVISOR_W  = 9
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  den_ff, den_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIVIDEND_W-1]};
      fits    = trial >= {1'b0, den_ff};
      diff    = trial - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/bvwm_window.sv
// ----------------------------------------------------------------------------
// Sample window
// Shift line of raw samples that rotates past a single tap to find the
// maximum and then the sum and count of the samples close to it.
// ----------------------------------------------------------------------------
module bvwm_window
   import bvwm_pkg::*;
#(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  win_ctrl_type                                 ctrl,
   input  logic [SAMPLE_W-1:0]                          sample,
   input  logic [GAP_W-1:0]                             gap,
   output win_stat_type                                 stat,
   output logic [$clog2(WINDOW_DEPTH*MAX_SAMPLE+1)-1:0] sum,
   output logic [$clog2(WINDOW_DEPTH+1)-1:0]            accepted
);

   localparam int SUM_W = $clog2(WINDOW_DEPTH * MAX_SAMPLE + 1);
   localparam int ACC_W = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W = $clog2(WINDOW_DEPTH);

   logic [SAMPLE_W-1:0] win_ff [WINDOW_DEPTH];
   logic [SAMPLE_W-1:0] win_in [WINDOW_DEPTH];
   win_state_type       state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                live_ff, live_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [SAMPLE_W-1:0] head;
   logic                live;
   logic                near;
   logic                last;

   always_comb begin
      head     = win_ff[0];
      live     = live_ff && (head != '0);
      near     = ({1'b0, head} + {1'b0, gap}) >= {1'b0, max_ff};
      last     = idx_ff == IDX_W'(WINDOW_DEPTH - 1);
      win_in   = win_ff;
      state_in = state_ff;
      idx_in   = idx_ff;
      live_in  = live_ff;
      max_in   = max_ff;
      sum_in   = sum_ff;
      acc_in   = acc_ff;
      if (state_ff == WIN_MAX || state_ff == WIN_SUM) begin
         for (int k = 0; k < WINDOW_DEPTH - 1; k++) begin
            win_in[k] = win_ff[k+1];
         end
         win_in[WINDOW_DEPTH-1] = win_ff[0];
      end
      unique case (state_ff)
         WIN_IDLE: begin
            if (ctrl.push) begin
               win_in[0] = sample;
               for (int k = 1; k < WINDOW_DEPTH; k++) begin
                  win_in[k] = win_ff[k-1];
               end
            end
            if (ctrl.start) begin
               state_in = WIN_MAX;
               idx_in   = '0;
               live_in  = 1'b1;
               max_in   = '0;
               sum_in   = '0;
               acc_in   = '0;
            end
         end
         WIN_MAX: begin
            if (live && head > max_ff) begin
               max_in = head;
            end
            live_in = live;
            idx_in  = idx_ff + IDX_W'(1);
            if (last) begin
               state_in = WIN_SUM;
               idx_in   = '0;
               live_in  = 1'b1;
            end
         end
         WIN_SUM: begin
            if (live && near) begin
               sum_in = sum_ff + SUM_W'(head);
               acc_in = acc_ff + ACC_W'(1);
            end
            live_in = live;
            idx_in  = idx_ff + IDX_W'(1);
            if (last) begin
               state_in = WIN_DONE;
            end
         end
         WIN_DONE: begin
            state_in = WIN_IDLE;
         end
         default: begin
            state_in = WIN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WIN_IDLE;
         idx_ff   <= '0;
         live_ff  <= 1'b0;
         for (int k = 0; k < WINDOW_DEPTH; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         live_ff  <= live_in;
         win_ff   <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in;
      sum_ff <= sum_in;
      acc_ff <= acc_in;
   end

   assign stat.done  = state_ff == WIN_DONE;
   assign stat.empty = max_ff == '0;
   assign sum        = sum_ff;
   assign accepted   = acc_ff;

endmodule

FILE: sim/battery_voltage_window_monitor_tb.sv
// ----------------------------------------------------------------------------
// Battery voltage window monitor testbench
// Drives sample and evaluate beats into the monitor and checks every reading
// against a cycle-free model of the window filter, the slow-falling reference,
// the charge curve and the low-battery alarm, or against fixed values. A short
// scripted sequence comes first, then randomised phases under several register
// settings, random gaps and stalls on both channels, and two long rsp stalls.
// ----------------------------------------------------------------------------
module battery_voltage_window_monitor_tb
   import bvwm_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH            = 16;
   localparam int DRAIN_CYCLES     = 150;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int HOLD_OFF_CYCLES  = 400;
   localparam int RANDOM_PHASES    = 6;
   localparam int PHASE_ITEMS      = 320;
   localparam int CURVE_POINTS     = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [CURVE_POINTS*MV_W-1:0] CHARGE_CURVE = {
      14'd7940, 14'd7740, 14'd7580, 14'd7460, 14'd7360, 14'd7300,
      14'd7240, 14'd7160, 14'd7020, 14'd6840, 14'd6500};

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MV_W-1:0]     battery_mv;
      logic [MV_W-1:0]     reference_mv;
      logic [PCT_W-1:0]    percent;
      logic                store_reference;
      logic                raise_alarm;
      logic                low_latched;
   } gauge_reading_type;

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  csr_idx;
      logic [CSR_DATA_W-1:0] csr_data;
      logic                  kind;
      logic [SAMPLE_W-1:0]   adc;
      logic [TIME_W-1:0]     stamp;
      logic                  typed;
      gauge_reading_type     fixed;
   } script_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_kind = KIND_SAMPLE;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic [TIME_W-1:0]     req_time_now = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [MV_W-1:0]       rsp_battery_mv;
   logic [MV_W-1:0]       rsp_reference_mv;
   logic [PCT_W-1:0]      rsp_percent;
   logic                  rsp_store_reference;
   logic                  rsp_raise_alarm;
   logic                  rsp_low_latched;

   // Model state.
   logic [SAMPLE_W-1:0] gauge_window [DEPTH];
   logic [MV_W-1:0]     held_reference = '0;
   logic [TIME_W-1:0]   reference_stamp = '0;
   logic [1:0]          low_run = '0;
   logic                alarm_set = 1'b0;
   logic [PCT_W-1:0]    held_percent = '0;
   logic [LIMIT_W-1:0]  cfg_limit = LOW_LIMIT_RESET;
   logic [GAP_W-1:0]    cfg_gap = GAP_RESET;
   logic [ELAPSE_W-1:0] cfg_elapse = ELAPSE_RESET;

   gauge_reading_type gauge_readings_due [$];
   script_row_type    script [$];
   int unsigned    fail_count = 0;
   int unsigned    results_seen = 0;
   int unsigned    silent_cycles = 0;
   bit             steady_flow = 1'b0;

   battery_voltage_window_monitor DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_sample          (req_sample),
      .req_time_now        (req_time_now),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_battery_mv      (rsp_battery_mv),
      .rsp_reference_mv    (rsp_reference_mv),
      .rsp_percent         (rsp_percent),
      .rsp_store_reference (rsp_store_reference),
      .rsp_raise_alarm     (rsp_raise_alarm),
      .rsp_low_latched     (rsp_low_latched)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PCT_W-1:0] charge_percent(input logic [MV_W-1:0] mv);
      int unsigned i;
      int unsigned lo;
      int unsigned hi;
      i = 0;
      while (i < CURVE_POINTS && mv >= CHARGE_CURVE[i*MV_W +: MV_W]) i++;
      if (i == 0) return '0;
      if (i >= CURVE_POINTS) return PCT_FULL;
      lo = CHARGE_CURVE[(i-1)*MV_W +: MV_W];
      hi = CHARGE_CURVE[i*MV_W +: MV_W];
      return PCT_W'(((mv - lo) * 10) / (hi - lo) + (i - 1) * 10);
   endfunction

   function automatic gauge_reading_type make_reading(
      input logic [STATUS_W-1:0] status, input logic [MV_W-1:0] battery_mv,
      input logic [MV_W-1:0] reference_mv, input logic [PCT_W-1:0] percent,
      input logic store, input logic raise, input logic latched);
      gauge_reading_type rd;
      rd.status          = status;
      rd.battery_mv      = battery_mv;
      rd.reference_mv    = reference_mv;
      rd.percent         = percent;
      rd.store_reference = store;
      rd.raise_alarm     = raise;
      rd.low_latched     = latched;
      return rd;
   endfunction

   task automatic predict_gauge(input logic kind, input logic [SAMPLE_W-1:0] adc,
                                input logic [TIME_W-1:0] stamp, output bit produced,
                                output gauge_reading_type rd);
      int unsigned count;
      int unsigned accepted;
      int unsigned maxv;
      int unsigned sum;
      int unsigned mv;
      int unsigned level;
      logic [TIME_W-1:0] elapsed;
      bit check;
      rd = '0;
      produced = 1'b0;
      if (kind == KIND_SAMPLE) begin
         for (int i = DEPTH - 1; i > 0; i--) gauge_window[i] = gauge_window[i-1];
         gauge_window[0] = adc;
      end else begin
         produced = 1'b1;
         count = 0;
         accepted = 0;
         maxv = 0;
         sum = 0;
         while (count < DEPTH && gauge_window[count] != 0) begin
            if (gauge_window[count] > maxv) maxv = gauge_window[count];
            count++;
         end
         for (int i = 0; i < count; i++) begin
            if (int'(gauge_window[i]) + int'(cfg_gap) >= maxv) begin
               sum += gauge_window[i];
               accepted++;
            end
         end
         if (count == 0 || accepted == 0) begin
            rd.status       = (count == 0) ? STATUS_EMPTY : STATUS_NONE_ACCEPTED;
            rd.reference_mv = held_reference;
            rd.percent      = held_percent;
            rd.low_latched  = alarm_set;
         end else begin
            mv = (26 * (sum / accepted)) / 10;
            level = held_reference;
            if (level == 0) begin
               level = mv;
               reference_stamp = stamp;
               rd.store_reference = 1'b1;
            end
            if (mv + 100 < level) begin
               elapsed = stamp - reference_stamp;
               if (elapsed > cfg_elapse) begin
                  reference_stamp = stamp;
                  if (mv + 150 < level) level -= 150;
                  else level = mv;
                  rd.store_reference = 1'b1;
               end
            end
            held_reference = level[MV_W-1:0];
            held_percent = charge_percent(held_reference);
            check = 1'b1;
            if (mv < cfg_limit) begin
               if (low_run < LOW_RUN_MAX) low_run++;
               if (low_run < LOW_RUN_MAX) check = 1'b0;
            end else begin
               low_run = '0;
            end
            if (check && held_reference < cfg_limit && mv < cfg_limit && !alarm_set) begin
               alarm_set = 1'b1;
               rd.raise_alarm = 1'b1;
            end
            rd.status       = STATUS_EVALUATED;
            rd.battery_mv   = mv[MV_W-1:0];
            rd.reference_mv = held_reference;
            rd.percent      = held_percent;
            rd.low_latched  = alarm_set;
         end
      end
   endtask

   task automatic add_item(input logic kind, input logic [SAMPLE_W-1:0] adc,
                           input logic [TIME_W-1:0] stamp);
      script_row_type row;
      row = '0;
      row.kind = kind;
      row.adc = adc;
      row.stamp = stamp;
      script.push_back(row);
   endtask

   task automatic add_fixed(input logic [SAMPLE_W-1:0] adc, input logic [TIME_W-1:0] stamp,
                            input gauge_reading_type rd);
      script_row_type row;
      row = '0;
      row.kind = KIND_EVALUATE;
      row.adc = adc;
      row.stamp = stamp;
      row.typed = 1'b1;
      row.fixed = rd;
      script.push_back(row);
   endtask

   task automatic add_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      script_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.csr_idx = idx;
      row.csr_data = data;
      script.push_back(row);
   endtask

   task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] adc,
                            input logic [TIME_W-1:0] stamp, input logic typed,
                            input gauge_reading_type fixed);
      int gap;
      bit produced;
      gauge_reading_type predicted;
      gap = steady_flow ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_sample <= adc;
      req_time_now <= stamp;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      predict_gauge(kind, adc, stamp, produced, predicted);
      if (produced) gauge_readings_due.push_back(typed ? fixed : predicted);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (gauge_readings_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_LOW_LIMIT: cfg_limit = data[LIMIT_W-1:0];
         CSR_GAP:       cfg_gap = data[GAP_W-1:0];
         CSR_ELAPSE:    cfg_elapse = data[ELAPSE_W-1:0];
         default:       ;
      endcase
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : reading_check
      gauge_reading_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         results_seen++;
         if (gauge_readings_due.size() == 0) begin
            $display("%0t: reading with none expected, expected nothing, got status %0d",
                     $time, rsp_status);
            fail_count++;
         end else begin
            want = gauge_readings_due.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("battery_mv", want.battery_mv, rsp_battery_mv);
            check_field("reference_mv", want.reference_mv, rsp_reference_mv);
            check_field("percent", want.percent, rsp_percent);
            check_field("store_reference", want.store_reference, rsp_store_reference);
            check_field("raise_alarm", want.raise_alarm, rsp_raise_alarm);
            check_field("low_latched", want.low_latched, rsp_low_latched);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         silent_cycles = 0;
      end else begin
         silent_cycles++;
         if (silent_cycles >= WATCHDOG_LIMIT) begin
            $display("[battery_voltage_window_monitor] ERROR");
            $finish;
         end
      end
   end

   // Reading side: random stalls, plus two long hold-offs that let the
   // monitor fill up while beats keep being offered.
   initial begin : reading_side
      int cycles;
      int holds_done;
      holds_done = 0;
      forever begin
         if (holds_done < 2 && results_seen >= 30 + 200 * holds_done) begin
            rsp_stall <= 1'b1;
            cycles = HOLD_OFF_CYCLES;
            holds_done++;
         end else if (!steady_flow && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            cycles = idle_length() + 1;
         end else begin
            rsp_stall <= 1'b0;
            cycles = $urandom_range(1, 8);
         end
         repeat (cycles) @(posedge clock);
      end
   end

   initial begin : stimulus
      script_row_type row;
      bit settled;
      int r;
      int level;
      logic kind;
      logic [SAMPLE_W-1:0] adc;
      logic [TIME_W-1:0] stamp;
      logic [TIME_W-1:0] now_ticks;
      logic [CSR_DATA_W-1:0] limit_value;
      logic [CSR_DATA_W-1:0] gap_value;
      logic [CSR_DATA_W-1:0] elapse_value;

      for (int i = 0; i < DEPTH; i++) gauge_window[i] = '0;

      add_fixed(12'd4095, 32'd0,
                make_reading(STATUS_EMPTY, 14'd0, 14'd0, 7'd0, 1'b0, 1'b0, 1'b0));
      add_item(KIND_SAMPLE, 12'd4095, 32'hFFFF_FFFF);
      add_fixed(12'd0, 32'd10,
                make_reading(STATUS_EVALUATED, 14'd10647, 14'd10647, PCT_FULL,
                             1'b1, 1'b0, 1'b0));
      add_item(KIND_SAMPLE, 12'd0, 32'd0);
      add_fixed(12'd0, 32'd20,
                make_reading(STATUS_EMPTY, 14'd0, 14'd10647, PCT_FULL, 1'b0, 1'b0, 1'b0));
      add_item(KIND_SAMPLE, 12'd4049, 32'd0);
      add_item(KIND_EVALUATE, 12'd0, 32'd100);
      add_item(KIND_SAMPLE, 12'd1, 32'd0);
      add_item(KIND_EVALUATE, 12'd0, 32'd110);
      add_item(KIND_SAMPLE, 12'd0, 32'd0);
      add_item(KIND_SAMPLE, 12'd2600, 32'd0);
      add_item(KIND_EVALUATE, 12'd0, 32'd130);
      add_item(KIND_EVALUATE, 12'd0, 32'd160);
      add_item(KIND_EVALUATE, 12'd0, 32'd161);
      add_item(KIND_EVALUATE, 12'd0, 32'hFFFF_FFFF);
      add_csr(CSR_LOW_LIMIT, 16'd16383);
      add_csr(CSR_GAP, 16'd4095);
      add_csr(CSR_ELAPSE, 16'd0);
      add_csr(CSR_UNUSED, 16'hFFFF);
      add_item(KIND_SAMPLE, 12'd4095, 32'd0);
      add_item(KIND_EVALUATE, 12'd0, 32'd5);
      add_item(KIND_EVALUATE, 12'd0, 32'd5);
      add_csr(CSR_LOW_LIMIT, 16'd0);
      add_csr(CSR_GAP, 16'd0);
      add_csr(CSR_ELAPSE, 16'hFFFF);
      add_item(KIND_SAMPLE, 12'd1, 32'd0);
      add_item(KIND_EVALUATE, 12'd0, 32'd0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      settled = 1'b1;
      foreach (script[i]) begin
         row = script[i];
         if (row.is_csr) begin
            if (!settled) settle();
            settled = 1'b1;
            csr_write(row.csr_idx, row.csr_data);
         end else begin
            settled = 1'b0;
            send_item(row.kind, row.adc, row.stamp, row.typed, row.fixed);
         end
      end

      level = 3150;
      now_ticks = 32'd200;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         case (phase)
            0: begin
               limit_value = LOW_LIMIT_RESET;
               gap_value = GAP_RESET;
               elapse_value = ELAPSE_RESET;
            end
            1: begin
               limit_value = 16'd16383;
               gap_value = 16'd4095;
               elapse_value = 16'd0;
            end
            2: begin
               limit_value = 16'd0;
               gap_value = 16'd0;
               elapse_value = 16'hFFFF;
            end
            default: begin
               limit_value = CSR_DATA_W'($urandom_range(6500, 7600));
               gap_value = CSR_DATA_W'($urandom_range(0, 400));
               elapse_value = CSR_DATA_W'($urandom_range(0, 200));
            end
         endcase
         csr_write(CSR_LOW_LIMIT, limit_value);
         csr_write(CSR_GAP, gap_value);
         csr_write(CSR_ELAPSE, elapse_value);
         steady_flow = (phase == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
               kind = KIND_SAMPLE;
               stamp = $urandom;
               if (r < 72) adc = SAMPLE_W'(level + int'($urandom_range(0, 40)) - 20);
               else if (r < 78) adc = SAMPLE_W'($urandom);
               else adc = '0;
            end else begin
               kind = KIND_EVALUATE;
               adc = SAMPLE_W'($urandom);
               if ($urandom_range(0, 19) == 0) now_ticks = $urandom;
               else now_ticks = now_ticks + $urandom_range(0, 120);
               stamp = now_ticks;
               if ($urandom_range(0, 29) == 0) level = $urandom_range(2300, 3200);
               else if (level > 2300) level -= $urandom_range(0, 3);
            end
            send_item(kind, adc, stamp, 1'b0, '0);
         end
      end

      steady_flow = 1'b0;
      settle();
      if (fail_count == 0) begin
         $display("[battery_voltage_window_monitor] OK");
      end else begin
         $display("[battery_voltage_window_monitor] ERROR");
      end
      $finish;
   end

endmodule
